### rtl/core/tsr_pkg.sv
// tsr_pkg: shared constants, widths, state and register index codes
// for the trapezoid speed ramp; no dependencies
`timescale 1ns / 1ps

package tsr_pkg;

  localparam int PATH_W   = 32;
  localparam int SPEED_W  = 15;
  localparam int ACC_W    = 15;
  localparam int DIVR_W   = 16;
  localparam int REM_W    = 31;
  localparam int TICK_W   = 17;
  localparam int AVG_W    = PATH_W + 1;

  localparam logic [TICK_W-1:0] TICK_SAT = 17'd65536;
  localparam logic [REM_W-1:0]  REM_MAX  = 31'h7FFF_FFFF;

  // input opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // serial multiplier: multiplicand a, multiplier b, one multiplier bit per cycle
  localparam int MUL_A_W   = 2 * SPEED_W;
  localparam int MUL_B_W   = DIVR_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_STEPS = MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  // serial restoring divider: one quotient bit per cycle
  localparam int DVS_W     = ACC_W + 1;
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQR  = 5'b00010,
    S_SCL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    CFG_TARGET_PATH    = 2'd0,
    CFG_REQUIRED_SPEED = 2'd1,
    CFG_ACCELERATION   = 2'd2,
    CFG_ACCEL_DIVIDER  = 2'd3
  } cfg_idx_t;

endpackage

### rtl/core/tsr_mul.sv
// tsr_mul: shift-add multiplier, one multiplier bit per cycle
// depends on tsr_pkg
`timescale 1ns / 1ps

module tsr_mul import tsr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [PROD_W-1:0]  prod
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MUL_A_W-1:0]   mcand;
  logic [MUL_A_W:0]     sum;

  // upper half plus multiplicand when the low multiplier bit is set
  assign sum = {1'b0, prod[PROD_W-1:MUL_B_W]} + (prod[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      prod  <= {{MUL_A_W{1'b0}}, b};
    end else if (busy) begin
      prod <= {sum, prod[MUL_B_W-1:1]};
    end
  end

endmodule

### rtl/core/tsr_div.sv
// tsr_div: restoring divider, one quotient bit per cycle
// depends on tsr_pkg
`timescale 1ns / 1ps

module tsr_div import tsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic              done,
  output logic [PROD_W-1:0] quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W-1:0]     dvs;
  logic [DVS_W-1:0]     part;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;
  logic                 fits;

  // bring down the next dividend bit and try the subtract
  assign trial = {part, quot[PROD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= divisor;
      part <= '0;
      quot <= dividend;
    end else if (busy) begin
      part <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quot <= {quot[PROD_W-2:0], fits};
    end
  end

endmodule

### rtl/core/trapezoid_speed_ramp_with_brake.sv
// trapezoid_speed_ramp_with_brake: top level, sequencer and ramp state
// out_valid rises once an item has gone through the squaring and scaling
// multiply passes and the serial divide for the brake distance; a new item is
// taken only once the last one has committed its result, and a held result
// stalls the next item until it is taken
// reset (rst, synchronous): speed, goal and path cleared, tick counter
// saturated, forward direction, acceleration register 1, other configuration registers 0
`timescale 1ns / 1ps

module trapezoid_speed_ramp_with_brake import tsr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [PATH_W-1:0]   cfg_data,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                opcode,
  input  logic [PATH_W-1:0]   left_enc,
  input  logic [PATH_W-1:0]   right_enc,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SPEED_W-1:0]  speed_command,
  output logic                braking,
  output logic                arrived
);

  // configuration registers
  logic [PATH_W-1:0]  target_path;
  logic [SPEED_W-1:0] required_speed;
  logic [ACC_W-1:0]   acceleration;
  logic [DIVR_W-1:0]  accel_divider;

  // ramp state
  logic [SPEED_W-1:0] ramp_speed;
  logic [TICK_W-1:0]  tick_counter;
  logic [SPEED_W-1:0] goal_speed;
  logic [REM_W-1:0]   remaining_target;
  logic               direction_reverse;
  logic [AVG_W-1:0]   avg;

  state_t state;

  logic in_fire;
  logic commit;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  // tick result is committed once the result slot is free or being emptied
  assign commit   = (state == S_DONE) && (!out_valid || out_ready);

  // ---------------------------------------------------------------
  // accept stage: direction, path load and averaged wheel path
  // ---------------------------------------------------------------
  logic               dir_new;
  logic [PATH_W-1:0]  tp_mag;
  logic [REM_W-1:0]   rem_load;
  logic [AVG_W:0]     path_sum;
  logic [AVG_W:0]     path_dir;
  logic [AVG_W:0]     path_rnd;

  always_comb begin
    dir_new  = (opcode == OP_START) ? target_path[PATH_W-1] : direction_reverse;
    tp_mag   = target_path[PATH_W-1] ? (~target_path + 1'b1) : target_path;
    // most negative target saturates to the largest magnitude
    rem_load = tp_mag[PATH_W-1] ? REM_MAX : tp_mag[REM_W-1:0];
    path_sum = {{2{left_enc[PATH_W-1]}}, left_enc}
             + {{2{right_enc[PATH_W-1]}}, right_enc};
    path_dir = dir_new ? (~path_sum + 1'b1) : path_sum;
    // halve with truncation toward zero
    path_rnd = path_dir + {{AVG_W{1'b0}}, path_dir[AVG_W]};
  end

  // ---------------------------------------------------------------
  // brake distance: speed^2 * divider / (2 * acceleration)
  // ---------------------------------------------------------------
  logic               mul_start;
  logic               mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic               div_start;
  logic               div_done;
  logic [PROD_W-1:0]  brake_dist;
  logic [ACC_W-1:0]   acc_eff;
  logic [DVS_W-1:0]   divisor;

  // zero acceleration behaves as one
  assign acc_eff = (acceleration == '0) ? ACC_W'(1) : acceleration;
  assign divisor = {acc_eff, 1'b0};

  // first pass squares the speed, second pass scales by the divider
  assign mul_start = in_fire || ((state == S_SQR) && mul_done);
  assign mul_a     = (state == S_IDLE) ? {{SPEED_W{1'b0}}, ramp_speed} : prod[MUL_A_W-1:0];
  assign mul_b     = (state == S_IDLE) ? {1'b0, ramp_speed} : accel_divider;
  assign div_start = (state == S_SCL) && mul_done;

  tsr_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  tsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (brake_dist)
  );

  // ---------------------------------------------------------------
  // final stage: brake and arrival checks, then the ramp step
  // ---------------------------------------------------------------
  logic signed [AVG_W+1:0]  rem_s;
  logic signed [AVG_W+1:0]  avg_s;
  logic signed [AVG_W+1:0]  avg2_s;
  logic signed [AVG_W+1:0]  to_go;
  logic signed [PROD_W+1:0] to_go_w;
  logic signed [PROD_W+1:0] brake_s;
  logic                     limited;
  logic                     plan_brake;
  logic                     at_target;
  logic [SPEED_W-1:0]       goal_eff;
  logic                     step;
  logic [SPEED_W:0]         up_sum;
  logic [SPEED_W:0]         floor_sum;
  logic [SPEED_W-1:0]       speed_next;
  logic [TICK_W-1:0]        tick_next;

  always_comb begin
    rem_s      = $signed({4'b0, remaining_target});
    avg_s      = $signed({{2{avg[AVG_W-1]}}, avg});
    avg2_s     = $signed({avg[AVG_W-1], avg, 1'b0});
    to_go      = rem_s - avg_s;
    to_go_w    = $signed({{(PROD_W - AVG_W){to_go[AVG_W+1]}}, to_go});
    brake_s    = $signed({2'b0, brake_dist});
    limited    = remaining_target != '0;
    plan_brake = limited && (avg2_s >= rem_s) && (to_go_w <= brake_s);
    at_target  = limited && (rem_s <= avg_s);
    goal_eff   = plan_brake ? SPEED_W'(1) : goal_speed;

    step      = (tick_counter >= {1'b0, accel_divider}) && (ramp_speed != goal_eff);
    up_sum    = {1'b0, ramp_speed} + {1'b0, acc_eff};
    floor_sum = {1'b0, goal_eff} + {1'b0, acc_eff};
    if (ramp_speed > goal_eff) begin
      // step down, clamp at the goal
      speed_next = ({1'b0, ramp_speed} < floor_sum) ? goal_eff : (ramp_speed - acc_eff);
    end else begin
      // step up, clamp at the goal
      speed_next = (up_sum > {1'b0, goal_eff}) ? goal_eff : up_sum[SPEED_W-1:0];
    end

    if (tick_counter < TICK_SAT) begin
      tick_next = tick_counter + 1'b1;
    end else begin
      tick_next = tick_counter;
    end
  end

  // ---------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      target_path       <= '0;
      required_speed    <= '0;
      acceleration      <= ACC_W'(1);
      accel_divider     <= '0;
      ramp_speed        <= '0;
      tick_counter      <= TICK_SAT;
      goal_speed        <= '0;
      remaining_target  <= '0;
      direction_reverse <= 1'b0;
      state             <= S_IDLE;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_TARGET_PATH:    target_path    <= cfg_data;
          CFG_REQUIRED_SPEED: required_speed <= cfg_data[SPEED_W-1:0];
          CFG_ACCELERATION:   acceleration   <= cfg_data[ACC_W-1:0];
          CFG_ACCEL_DIVIDER:  accel_divider  <= cfg_data[DIVR_W-1:0];
          default: ;
        endcase
      end

      // new result beat offered, or the held one taken
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            // start item loads direction, path and goal
            if (opcode == OP_START) begin
              direction_reverse <= target_path[PATH_W-1];
              remaining_target  <= rem_load;
              goal_speed        <= required_speed;
            end
            state <= S_SQR;
          end
        end
        S_SQR: begin
          if (mul_done) begin
            state <= S_SCL;
          end
        end
        S_SCL: begin
          if (mul_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // wait for a free result slot before committing the tick
          if (commit) begin
            state <= S_IDLE;
            if (at_target) begin
              ramp_speed       <= '0;
              tick_counter     <= TICK_SAT;
              goal_speed       <= '0;
              remaining_target <= '0;
            end else begin
              goal_speed <= goal_eff;
              if (step) begin
                ramp_speed   <= speed_next;
                tick_counter <= '0;
              end else begin
                tick_counter <= tick_next;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      avg <= path_rnd[AVG_W:1];
    end
    if (commit) begin
      speed_command <= at_target ? '0 : (step ? speed_next : ramp_speed);
      braking       <= plan_brake;
      arrived       <= at_target;
    end
  end

endmodule

### dv/trapezoid_speed_ramp_with_brake_tb.sv
// trapezoid_speed_ramp_with_brake_tb: self-checking bench for the speed ramp generator
// drives start and tick beats, predicts speed, brake and arrival flags per beat;
// depends on tsr_pkg and trapezoid_speed_ramp_with_brake
`timescale 1ns / 1ps

module trapezoid_speed_ramp_with_brake_tb;
  import tsr_pkg::*;

  // pause before a register write
  localparam int SETTLE_CYCLES = 120;
  // cycles without any beat or write before the run is called hung
  localparam int QUIET_LIMIT   = 5000;
  // receiver back-pressure stretch, long enough to fill the block
  localparam int HOLD_CYCLES   = 700;
  localparam int RANDOM_PHASES = 10;
  localparam int BEATS_PER_PHASE = 36;

  typedef struct packed {
    logic              op;
    logic [PATH_W-1:0] lpath;
    logic [PATH_W-1:0] rpath;
  } tick_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               brake_flag;
    logic               arrive_flag;
  } speed_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_write  = 1'b0;
  logic [1:0]        cfg_index  = '0;
  logic [PATH_W-1:0] cfg_data   = '0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic              opcode     = 1'b0;
  logic [PATH_W-1:0] left_enc   = '0;
  logic [PATH_W-1:0] right_enc  = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [SPEED_W-1:0] speed_command;
  logic              braking;
  logic              arrived;

  trapezoid_speed_ramp_with_brake DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .left_enc     (left_enc),
    .right_enc    (right_enc),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .speed_command(speed_command),
    .braking      (braking),
    .arrived      (arrived)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow of the register file, updated once all four writes of a programming call are out
  logic signed [PATH_W-1:0] cfg_target    = '0;
  logic [ACC_W-1:0]         cfg_req_speed = '0;
  logic [ACC_W-1:0]         cfg_accel     = ACC_W'(1);
  logic [DIVR_W-1:0]        cfg_divider   = '0;

  // ramp state as the block should hold it, reset values
  logic [SPEED_W-1:0] ramp      = '0;
  logic [TICK_W-1:0]  tick_cnt  = TICK_SAT;
  logic [SPEED_W-1:0] goal      = '0;
  logic [REM_W-1:0]   path_left = '0;
  logic               go_reverse = 1'b0;

  tick_item_t  tick_queue[$];
  speed_beat_t speed_expected[$];
  tick_item_t  on_offer;

  int items_pushed = 0;
  int ticks_taken  = 0;
  int speeds_seen  = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_arm  = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  // one control tick: optional reload, brake planning, arrival, then the ramp step
  function automatic speed_beat_t advance_ramp(tick_item_t it);
    longint l, r, avg, rem, brake, tgt;
    longint unsigned sq;
    int s, g;
    logic [ACC_W-1:0] acc;
    speed_beat_t res;
    acc = (cfg_accel == '0) ? ACC_W'(1) : cfg_accel;
    l = longint'(signed'(it.lpath));
    r = longint'(signed'(it.rpath));
    res = '0;
    if (it.op == OP_START) begin
      tgt = longint'(cfg_target);
      go_reverse = (tgt < 0);
      if (tgt < 0) tgt = -tgt;
      // most negative target saturates its magnitude
      path_left = (tgt > longint'(REM_MAX)) ? REM_MAX : REM_W'(tgt);
      goal = cfg_req_speed;
    end
    if (go_reverse) begin
      l = -l;
      r = -r;
    end
    if (path_left != '0) begin
      avg = (l + r) / 2;
      rem = longint'(path_left);
      sq = 64'(ramp);
      brake = longint'((sq * sq * 64'(cfg_divider)) / (64'd2 * 64'(acc)));
      if (avg + avg >= rem && rem - avg <= brake) begin
        goal = SPEED_W'(1);
        res.brake_flag = 1'b1;
      end
      if (rem <= avg) begin
        ramp = '0;
        tick_cnt = TICK_SAT;
        goal = '0;
        path_left = '0;
        res.arrive_flag = 1'b1;
        return res;
      end
    end
    if (tick_cnt >= TICK_W'(cfg_divider) && ramp != goal) begin
      s = int'(ramp);
      g = int'(goal);
      if (s > g) begin
        s -= int'(acc);
        if (s < g) s = g;
      end else begin
        s += int'(acc);
        if (s > g) s = g;
      end
      ramp = SPEED_W'(s);
      tick_cnt = '0;
    end else if (tick_cnt < TICK_SAT) begin
      tick_cnt++;
    end
    res.speed = ramp;
    return res;
  endfunction

  // driver: holds each beat until taken, predicts at the accepting edge
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        speed_expected.push_back(advance_ramp(on_offer));
        ticks_taken++;
      end
      if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        on_offer = tick_queue.pop_front();
        in_valid   <= 1'b1;
        opcode     <= on_offer.op;
        left_enc   <= on_offer.lpath;
        right_enc  <= on_offer.rpath;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each result beat, drives out_ready with random stalls
  always @(posedge clk) begin
    speed_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        speeds_seen++;
        if (speed_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d with nothing expected: speed %0d braking %0b arrived %0b",
                     speeds_seen, speed_command, braking, arrived);
        end else begin
          want = speed_expected.pop_front();
          if (speed_command !== want.speed || braking !== want.brake_flag ||
              arrived !== want.arrive_flag) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"beat %0d: expected speed %0d braking %0b arrived %0b, ",
                        "got speed %0d braking %0b arrived %0b"},
                       speeds_seen, want.speed, want.brake_flag, want.arrive_flag,
                       speed_command, braking, arrived);
          end
        end
      end
      if (hold_arm && !hold_done) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on stretches with no beat and no register write
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: %0d cycles without a beat", quiet_cycles);
      $display("trapezoid_speed_ramp_with_brake_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(logic op, logic [PATH_W-1:0] lp, logic [PATH_W-1:0] rp);
    tick_item_t it;
    it.op = op;
    it.lpath = lp;
    it.rpath = rp;
    tick_queue.push_back(it);
    items_pushed++;
  endtask

  // wheel paths around a travelled distance, mirrored when moving backward
  task automatic push_track(logic op, longint pos, bit rev);
    longint l, r;
    l = pos + $urandom_range(0, 3);
    r = pos - $urandom_range(0, 3);
    if (rev) begin
      l = -l;
      r = -r;
    end
    push_item(op, PATH_W'(l), PATH_W'(r));
  endtask

  // a start beat, then ticks whose paths grow toward and past the target,
  // with some noise beats and restarts mixed in
  task automatic queue_move(int n_ticks);
    longint pos, tmag, step_max;
    bit rev;
    int roll;
    tmag = longint'(cfg_target);
    rev = (tmag < 0);
    if (rev) tmag = -tmag;
    step_max = (tmag == 0) ? 64'd5000 : tmag / $urandom_range(3, 24) + 1;
    pos = $urandom_range(0, 20);
    push_track(OP_START, pos, rev);
    repeat (n_ticks) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        push_item(logic'($urandom_range(1)), $urandom, $urandom);
      end else if (roll < 8) begin
        push_track(OP_START, pos, rev);
      end else begin
        pos += longint'($urandom) % (step_max + 1);
        push_track(OP_TICK, pos, rev);
      end
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [PATH_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic program_regs(logic [PATH_W-1:0] tgt, logic [ACC_W-1:0] req,
                              logic [ACC_W-1:0] acc, logic [DIVR_W-1:0] div);
    write_reg(CFG_TARGET_PATH, tgt);
    write_reg(CFG_REQUIRED_SPEED, PATH_W'(req));
    write_reg(CFG_ACCELERATION, PATH_W'(acc));
    write_reg(CFG_ACCEL_DIVIDER, PATH_W'(div));
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_target    = tgt;
    cfg_req_speed = req;
    cfg_accel     = acc;
    cfg_divider   = div;
  endtask

  // random settings with a fair share of extremes
  task automatic program_random_regs();
    logic [PATH_W-1:0] tgt;
    logic [ACC_W-1:0]  req, acc;
    logic [DIVR_W-1:0] div;
    int mag;
    case ($urandom_range(7))
      0: tgt = '0;
      1: tgt = 32'h8000_0000;
      2: tgt = 32'h7FFF_FFFF;
      3: tgt = $urandom_range(1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
      default: begin
        mag = $urandom_range(1, 200000);
        tgt = $urandom_range(1) ? PATH_W'(-mag) : PATH_W'(mag);
      end
    endcase
    case ($urandom_range(5))
      0: req = '0;
      1: req = '1;
      default: req = ACC_W'($urandom);
    endcase
    case ($urandom_range(5))
      0: acc = '0;
      1: acc = ACC_W'(1);
      2: acc = '1;
      default: acc = ACC_W'($urandom_range(1, 2000));
    endcase
    case ($urandom_range(5))
      0: div = '0;
      1: div = '1;
      default: div = DIVR_W'($urandom_range(0, 6));
    endcase
    program_regs(tgt, req, acc, div);
  endtask

  // all beats taken, all results back, then let the block settle
  task automatic wait_drained();
    while (ticks_taken != items_pushed || speed_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase_base;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 84;

    // reset settings: no path limit, zero goal, extreme wheel paths
    push_item(OP_TICK, '0, '0);
    push_item(OP_START, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_item(OP_TICK, 32'h8000_0000, 32'h8000_0000);
    wait_drained();

    // forward move through cruise, planned braking and arrival
    program_regs(32'd1000, 15'd300, 15'd100, 16'd1);
    push_item(OP_START, '0, '0);
    push_item(OP_TICK, '0, '0);
    push_item(OP_TICK, 32'd100, 32'd100);
    push_item(OP_TICK, 32'd300, 32'd300);
    push_item(OP_TICK, 32'd600, 32'd600);
    push_item(OP_TICK, 32'd900, 32'd1000);
    push_item(OP_TICK, 32'd1000, 32'd999);
    push_item(OP_TICK, 32'd1001, 32'd1000);
    push_item(OP_TICK, 32'd5, 32'd5);
    wait_drained();

    // most negative target with zero acceleration, extreme paths reversed
    program_regs(32'h8000_0000, '1, '0, '0);
    push_item(OP_START, 32'h7FFF_FFFF, 32'h8000_0000);
    push_item(OP_TICK, 32'h8000_0000, 32'h8000_0000);
    wait_drained();

    // short reverse move at full speed and largest divider, odd path sums
    program_regs(-32'sd5, '1, '1, '1);
    push_item(OP_START, '0, '0);
    push_item(OP_TICK, -32'sd1, -32'sd2);
    push_item(OP_TICK, -32'sd3, -32'sd3);
    push_item(OP_TICK, -32'sd5, -32'sd6);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 84;
        recv_idle_pct = 29;
      end else if (ph == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_random_regs();
      phase_base = items_pushed;
      while (items_pushed - phase_base < BEATS_PER_PHASE) queue_move($urandom_range(6, 40));
      // long receiver stall while the sender keeps offering
      if (ph == 8) hold_arm = 1'b1;
      wait_drained();
    end

    if (mismatches == 0 && speed_expected.size() == 0)
      $display("trapezoid_speed_ramp_with_brake_tb: PASS");
    else
      $display("trapezoid_speed_ramp_with_brake_tb: FAIL");
    $finish;
  end

endmodule
